/* src/count_tree_kth_select_defines.svh */
// assertion macros shared by the block
`ifndef COUNT_TREE_KTH_SELECT_DEFINES_SVH
`define COUNT_TREE_KTH_SELECT_DEFINES_SVH

// same-cycle implication, sampled on the block clock
`define CTKS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the block clock
`define CTKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ctks_pkg.sv */
package ctks_pkg;

  // tree geometry
  localparam int LEAF_COUNT = 1024;
  localparam int LEAF_BITS  = $clog2(LEAF_COUNT);
  localparam int NODE_BITS  = LEAF_BITS + 1;
  localparam int NODE_DEPTH = 2 ** NODE_BITS;

  // field widths
  localparam int SUM_W   = 48;
  localparam int RANK_W  = 32;
  localparam int SLOT_W  = 11;
  localparam int DELTA_W = 32;

  // request command codes
  typedef enum logic [1:0] {
    CMD_TAKE  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RANGE = 2'd2
  } ctks_cmd_e;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TK_ROOT,
    ST_TK_CHK,
    ST_DS_ISSUE,
    ST_DS_EVAL,
    ST_AD_CHK,
    ST_LF_EVAL,
    ST_RF_ISSUE,
    ST_RF_EVAL,
    ST_RG_ISSUE,
    ST_RG_EVAL,
    ST_OUT_HIT,
    ST_OUT_MISS,
    ST_OUT_RANGE
  } ctks_state_e;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LD_TAKE,
    DP_LD_ADD,
    DP_LD_RANGE,
    DP_DESCEND,
    DP_LEAF_TAKE,
    DP_LEAF_ADD,
    DP_REFRESH,
    DP_RANGE,
    DP_OUT_TAKE,
    DP_OUT_MISS,
    DP_OUT_RANGE
  } ctks_dp_op_e;

  // memory read address selection
  typedef enum logic [2:0] {
    RD_NODE,
    RD_ROOT,
    RD_LEFT,
    RD_SIB,
    RD_RANGE
  } ctks_rd_sel_e;

  // controller to datapath
  typedef struct packed {
    ctks_dp_op_e  op;
    ctks_rd_sel_e rd_sel;
  } ctks_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic root_ok;
    logic leaf;
    logic slot_ok;
    logic add_ok;
    logic at_root;
    logic range_done;
  } ctks_stat_t;

endpackage

/* src/ctks_datapath.sv */
module ctks_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ctks_pkg::ctks_ctl_t                    ctl_i,
  input  logic [ctks_pkg::RANK_W-1:0]            rank_i,
  input  logic [ctks_pkg::SLOT_W-1:0]            slot_index_i,
  input  logic signed [ctks_pkg::DELTA_W-1:0]    delta_i,
  input  logic [ctks_pkg::SLOT_W-1:0]            range_low_i,
  input  logic [ctks_pkg::SLOT_W-1:0]            range_high_i,
  output ctks_pkg::ctks_stat_t                   stat_o,
  output logic                                   kind_o,
  output logic                                   found_o,
  output logic [ctks_pkg::SLOT_W-1:0]            slot_o,
  output logic signed [ctks_pkg::SUM_W-1:0]      total_o
);

  localparam int NB = ctks_pkg::NODE_BITS;
  localparam int LB = ctks_pkg::LEAF_BITS;
  localparam int SW = ctks_pkg::SUM_W;
  localparam int LW = ctks_pkg::SLOT_W;

  // sum tree memory
  logic [SW-1:0] mem_q [ctks_pkg::NODE_DEPTH];
  logic [SW-1:0] rd_a_q, rd_b_q;
  logic [NB-1:0] ra_a, ra_b, wa;
  logic [SW-1:0] wd;
  logic          we;

  // working registers
  logic [NB-1:0]                 node_q, l_q, r_q, clr_q;
  logic [SW-1:0]                 acc_q, cur_q, sum_q;
  logic [ctks_pkg::RANK_W-1:0]   rank_q;
  logic [ctks_pkg::DELTA_W-1:0]  delta_q;
  logic [LW-1:0]                 slot_q;
  logic                          add_ok_q;
  logic                          kind_q, found_q;
  logic [LW-1:0]                 out_slot_q;
  logic [SW-1:0]                 total_q;

  // descent compare and root check
  logic signed [SW:0] left_sum, rank_ext, root_ext;
  logic               go_right;

  assign left_sum = {acc_q[SW-1], acc_q} + {rd_a_q[SW-1], rd_a_q};
  assign rank_ext = {{(SW + 1 - ctks_pkg::RANK_W){1'b0}}, rank_q};
  assign root_ext = {rd_a_q[SW-1], rd_a_q};
  assign go_right = left_sum < rank_ext;

  // leaf updates and upward refresh
  logic [SW-1:0] leaf_dec, leaf_add, up_sum, delta_ext;

  assign delta_ext = {{(SW - ctks_pkg::DELTA_W){delta_q[ctks_pkg::DELTA_W-1]}}, delta_q};
  assign leaf_dec  = rd_a_q - SW'(1);
  assign leaf_add  = rd_a_q + delta_ext;
  assign up_sum    = cur_q + rd_a_q;

  // range step: left edge odd and right edge even contribute
  logic          l_odd, r_even;
  logic [NB:0]   l_inc;
  logic [NB-1:0] r_dec;
  logic [SW-1:0] add_a, add_b, range_sum;

  assign l_odd     = l_q[0];
  assign r_even    = ~r_q[0];
  assign l_inc     = {1'b0, l_q} + {{NB{1'b0}}, l_odd};
  assign r_dec     = r_q - {{(NB - 1){1'b0}}, r_even};
  assign add_a     = l_odd ? rd_a_q : '0;
  assign add_b     = r_even ? rd_b_q : '0;
  assign range_sum = sum_q + add_a + add_b;

  // request decode for loads
  logic [LW-1:0] slot_m1, lo_c, hi_c, lo_m1, hi_m1;
  logic          add_ok, rng_empty;

  assign slot_m1   = slot_index_i - LW'(1);
  assign add_ok    = (slot_index_i != '0) && (slot_index_i <= LW'(ctks_pkg::LEAF_COUNT));
  assign lo_c      = (range_low_i == '0) ? LW'(1) : range_low_i;
  assign hi_c      = (range_high_i > LW'(ctks_pkg::LEAF_COUNT)) ?
                     LW'(ctks_pkg::LEAF_COUNT) : range_high_i;
  assign lo_m1     = lo_c - LW'(1);
  assign hi_m1     = hi_c - LW'(1);
  assign rng_empty = lo_c > hi_c;

  // read address selection
  always_comb begin
    ra_a = node_q;
    ra_b = r_q;
    case (ctl_i.rd_sel)
      ctks_pkg::RD_NODE:  ra_a = node_q;
      ctks_pkg::RD_ROOT:  ra_a = NB'(1);
      ctks_pkg::RD_LEFT:  ra_a = {node_q[NB-2:0], 1'b0};
      ctks_pkg::RD_SIB:   ra_a = node_q ^ NB'(1);
      ctks_pkg::RD_RANGE: ra_a = l_q;
      default:            ra_a = node_q;
    endcase
  end

  // write port
  always_comb begin
    we = 1'b0;
    wa = node_q;
    wd = '0;
    case (ctl_i.op)
      ctks_pkg::DP_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
      end
      ctks_pkg::DP_LEAF_TAKE: begin
        we = 1'b1;
        wd = leaf_dec;
      end
      ctks_pkg::DP_LEAF_ADD: begin
        we = 1'b1;
        wd = leaf_add;
      end
      ctks_pkg::DP_REFRESH: begin
        we = 1'b1;
        wa = node_q >> 1;
        wd = up_sum;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_a_q <= mem_q[ra_a];
    rd_b_q <= mem_q[ra_b];
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.op == ctks_pkg::DP_CLEAR) begin
      clr_q <= clr_q + NB'(1);
    end
  end

  // working registers and result register
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      ctks_pkg::DP_LD_TAKE: begin
        rank_q <= rank_i;
        node_q <= NB'(1);
        acc_q  <= '0;
      end
      ctks_pkg::DP_LD_ADD: begin
        delta_q  <= delta_i;
        add_ok_q <= add_ok;
        node_q   <= {1'b1, slot_m1[LB-1:0]};
      end
      ctks_pkg::DP_LD_RANGE: begin
        sum_q <= '0;
        if (rng_empty) begin
          // empty range: start with left edge past right edge
          l_q <= NB'(1);
          r_q <= '0;
        end else begin
          l_q <= {1'b1, lo_m1[LB-1:0]};
          r_q <= {1'b1, hi_m1[LB-1:0]};
        end
      end
      ctks_pkg::DP_DESCEND: begin
        if (go_right) begin
          acc_q  <= left_sum[SW-1:0];
          node_q <= {node_q[NB-2:0], 1'b1};
        end else begin
          node_q <= {node_q[NB-2:0], 1'b0};
        end
      end
      ctks_pkg::DP_LEAF_TAKE: begin
        cur_q  <= leaf_dec;
        slot_q <= LW'(node_q[LB-1:0]) + LW'(1);
      end
      ctks_pkg::DP_LEAF_ADD: begin
        cur_q <= leaf_add;
      end
      ctks_pkg::DP_REFRESH: begin
        cur_q  <= up_sum;
        node_q <= node_q >> 1;
      end
      ctks_pkg::DP_RANGE: begin
        sum_q <= range_sum;
        l_q   <= l_inc[NB:1];
        r_q   <= {1'b0, r_dec[NB-1:1]};
      end
      ctks_pkg::DP_OUT_TAKE: begin
        kind_q     <= 1'b0;
        found_q    <= 1'b1;
        out_slot_q <= slot_q;
        total_q    <= '0;
      end
      ctks_pkg::DP_OUT_MISS: begin
        kind_q     <= 1'b0;
        found_q    <= 1'b0;
        out_slot_q <= '0;
        total_q    <= '0;
      end
      ctks_pkg::DP_OUT_RANGE: begin
        kind_q     <= 1'b1;
        found_q    <= 1'b0;
        out_slot_q <= '0;
        total_q    <= sum_q;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  // status toward the controller
  assign stat_o.clr_done   = clr_q == {NB{1'b1}};
  assign stat_o.root_ok    = (rank_q != '0) && !(root_ext < rank_ext);
  assign stat_o.leaf       = node_q[NB-1];
  assign stat_o.slot_ok    = {1'b0, node_q[LB-1:0]} < (LB + 1)'(ctks_pkg::LEAF_COUNT);
  assign stat_o.add_ok     = add_ok_q;
  assign stat_o.at_root    = node_q == NB'(1);
  assign stat_o.range_done = l_q > r_q;

  assign kind_o  = kind_q;
  assign found_o = found_q;
  assign slot_o  = out_slot_q;
  assign total_o = total_q;

endmodule

/* src/ctks_ctrl.sv */
module ctks_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            cmd_i,
  input  logic                  out_ready_i,
  input  ctks_pkg::ctks_stat_t  stat_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output ctks_pkg::ctks_ctl_t   ctl_o
);

  ctks_pkg::ctks_state_e state_q, state_d;
  logic                  take_q, take_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free, out_load;

  assign out_free = ~out_valid_q | out_ready_i;

  // state and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctks_pkg::ST_CLEAR;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      take_q      <= take_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    take_d        = take_q;
    out_load      = 1'b0;
    in_ready_o    = 1'b0;
    ctl_o.op      = ctks_pkg::DP_NOP;
    ctl_o.rd_sel  = ctks_pkg::RD_NODE;
    case (state_q)
      ctks_pkg::ST_CLEAR: begin
        ctl_o.op = ctks_pkg::DP_CLEAR;
        if (stat_i.clr_done) state_d = ctks_pkg::ST_IDLE;
      end
      ctks_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_i)
            ctks_pkg::CMD_TAKE: begin
              ctl_o.op = ctks_pkg::DP_LD_TAKE;
              take_d   = 1'b1;
              state_d  = ctks_pkg::ST_TK_ROOT;
            end
            ctks_pkg::CMD_ADD: begin
              ctl_o.op = ctks_pkg::DP_LD_ADD;
              take_d   = 1'b0;
              state_d  = ctks_pkg::ST_AD_CHK;
            end
            ctks_pkg::CMD_RANGE: begin
              ctl_o.op = ctks_pkg::DP_LD_RANGE;
              state_d  = ctks_pkg::ST_RG_ISSUE;
            end
            default: state_d = ctks_pkg::ST_IDLE;
          endcase
        end
      end
      ctks_pkg::ST_TK_ROOT: begin
        ctl_o.rd_sel = ctks_pkg::RD_ROOT;
        state_d      = ctks_pkg::ST_TK_CHK;
      end
      ctks_pkg::ST_TK_CHK: begin
        state_d = stat_i.root_ok ? ctks_pkg::ST_DS_ISSUE : ctks_pkg::ST_OUT_MISS;
      end
      ctks_pkg::ST_DS_ISSUE: begin
        if (stat_i.leaf) begin
          if (stat_i.slot_ok) begin
            ctl_o.rd_sel = ctks_pkg::RD_NODE;
            state_d      = ctks_pkg::ST_LF_EVAL;
          end else begin
            state_d = ctks_pkg::ST_OUT_MISS;
          end
        end else begin
          ctl_o.rd_sel = ctks_pkg::RD_LEFT;
          state_d      = ctks_pkg::ST_DS_EVAL;
        end
      end
      ctks_pkg::ST_DS_EVAL: begin
        ctl_o.op = ctks_pkg::DP_DESCEND;
        state_d  = ctks_pkg::ST_DS_ISSUE;
      end
      ctks_pkg::ST_AD_CHK: begin
        if (stat_i.add_ok) begin
          ctl_o.rd_sel = ctks_pkg::RD_NODE;
          state_d      = ctks_pkg::ST_LF_EVAL;
        end else begin
          state_d = ctks_pkg::ST_IDLE;
        end
      end
      ctks_pkg::ST_LF_EVAL: begin
        ctl_o.op = take_q ? ctks_pkg::DP_LEAF_TAKE : ctks_pkg::DP_LEAF_ADD;
        state_d  = ctks_pkg::ST_RF_ISSUE;
      end
      ctks_pkg::ST_RF_ISSUE: begin
        if (stat_i.at_root) begin
          state_d = take_q ? ctks_pkg::ST_OUT_HIT : ctks_pkg::ST_IDLE;
        end else begin
          ctl_o.rd_sel = ctks_pkg::RD_SIB;
          state_d      = ctks_pkg::ST_RF_EVAL;
        end
      end
      ctks_pkg::ST_RF_EVAL: begin
        ctl_o.op = ctks_pkg::DP_REFRESH;
        state_d  = ctks_pkg::ST_RF_ISSUE;
      end
      ctks_pkg::ST_RG_ISSUE: begin
        if (stat_i.range_done) begin
          state_d = ctks_pkg::ST_OUT_RANGE;
        end else begin
          ctl_o.rd_sel = ctks_pkg::RD_RANGE;
          state_d      = ctks_pkg::ST_RG_EVAL;
        end
      end
      ctks_pkg::ST_RG_EVAL: begin
        ctl_o.op = ctks_pkg::DP_RANGE;
        state_d  = ctks_pkg::ST_RG_ISSUE;
      end
      ctks_pkg::ST_OUT_HIT: begin
        if (out_free) begin
          ctl_o.op = ctks_pkg::DP_OUT_TAKE;
          out_load = 1'b1;
          state_d  = ctks_pkg::ST_IDLE;
        end
      end
      ctks_pkg::ST_OUT_MISS: begin
        if (out_free) begin
          ctl_o.op = ctks_pkg::DP_OUT_MISS;
          out_load = 1'b1;
          state_d  = ctks_pkg::ST_IDLE;
        end
      end
      ctks_pkg::ST_OUT_RANGE: begin
        if (out_free) begin
          ctl_o.op = ctks_pkg::DP_OUT_RANGE;
          out_load = 1'b1;
          state_d  = ctks_pkg::ST_IDLE;
        end
      end
      default: state_d = ctks_pkg::ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/count_tree_kth_select.sv */
// count tree with k-th unit selection over LEAF_COUNT slot counts (1024 here)
// request channel (in_valid_i / in_ready_o): cmd_i picks take (0), add (1) or
// range sum (2); rank_i, slot_index_i, delta_i, range_low_i, range_high_i carry
// the operands. code 3 is accepted and ignored. add gives no result.
// result channel (out_valid_o / out_ready_i): kind_o, found_o, slot_o, total_o.
// one request is worked at a time. each tree level takes an issue state that
// sets the read address and an eval state that uses the registered read data,
// with L = log2(LEAF_COUNT) = 10 levels:
//   take      descends from the root to a leaf, then refreshes up to the root
//   add       updates the leaf and refreshes up, back to ready after the root write
//   range sum steps both edges up a level at a time until they cross
// a miss on take (rank 0 or beyond the root sum) returns after the root check.
// after reset all 2048 node memory entries are cleared, one entry a cycle, with
// in_ready_o low. the result sits in an output register: a stalled receiver
// holds it while the next request is accepted and worked; the block waits only
// when a second result is ready before the first is taken.
`include "count_tree_kth_select_defines.svh"

module count_tree_kth_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [ctks_pkg::RANK_W-1:0]         rank_i,
  input  logic [ctks_pkg::SLOT_W-1:0]         slot_index_i,
  input  logic signed [ctks_pkg::DELTA_W-1:0] delta_i,
  input  logic [ctks_pkg::SLOT_W-1:0]         range_low_i,
  input  logic [ctks_pkg::SLOT_W-1:0]         range_high_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic                                found_o,
  output logic [ctks_pkg::SLOT_W-1:0]         slot_o,
  output logic signed [ctks_pkg::SUM_W-1:0]   total_o
);

  ctks_pkg::ctks_ctl_t  ctl;
  ctks_pkg::ctks_stat_t stat;

  // sequencer
  ctks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  // tree memory and arithmetic
  ctks_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .rank_i       (rank_i),
    .slot_index_i (slot_index_i),
    .delta_i      (delta_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .stat_o       (stat),
    .kind_o       (kind_o),
    .found_o      (found_o),
    .slot_o       (slot_o),
    .total_o      (total_o)
  );

  // terms for the checks
  logic take_acc, root_rd, out_op, range_op, refresh_op;

  assign take_acc   = in_valid_i && in_ready_o && (cmd_i == ctks_pkg::CMD_TAKE);
  assign root_rd    = ctl.rd_sel == ctks_pkg::RD_ROOT;
  assign out_op     = (ctl.op == ctks_pkg::DP_OUT_TAKE) || (ctl.op == ctks_pkg::DP_OUT_MISS) ||
                      (ctl.op == ctks_pkg::DP_OUT_RANGE);
  assign range_op   = ctl.op == ctks_pkg::DP_RANGE;
  assign refresh_op = ctl.op == ctks_pkg::DP_REFRESH;

  // checks
  `CTKS_ASSERT_NEXT(a_take_reads_root, take_acc, root_rd, "take did not start at root")
  `CTKS_ASSERT_IMPL(a_no_result_overwrite, out_op, !out_valid_o || out_ready_i, "result lost")
  `CTKS_ASSERT_IMPL(a_range_step_live, range_op, !stat.range_done, "range step past end")
  `CTKS_ASSERT_IMPL(a_refresh_below_root, refresh_op, !stat.at_root, "refresh above root")

endmodule
